// File: rtl/bmorph_pkg.sv
package bmorph_pkg;

  localparam int PIX_W     = 8;
  localparam int COLS_W    = 11;
  localparam int ROWS_W    = 13;
  localparam int ROWPOS_W  = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_ROWS  = 4096;
  localparam int DEF_MAX_COLS = 1024;
  localparam int QDEPTH    = 4;
  localparam int WIN_N     = 9;

  localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;
  localparam logic [COLS_W-1:0] COLS_RESET = 11'd1024;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd1024;

  typedef enum logic [1:0] {
    MODE_ERODE  = 2'd0,
    MODE_DILATE = 2'd1,
    MODE_INNER  = 2'd2,
    MODE_OUTER  = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // window slots, row-major from the upper left
  localparam int W_TL = 0;
  localparam int W_TC = 1;
  localparam int W_TR = 2;
  localparam int W_ML = 3;
  localparam int W_MC = 4;
  localparam int W_MR = 5;
  localparam int W_BL = 6;
  localparam int W_BC = 7;
  localparam int W_BR = 8;

  typedef struct packed {
    logic             is_pix;
    logic             emit;
    logic             fwd_mid;
    logic             fwd_bl;
    logic             fwd_bc;
    logic [WIN_N-1:0] vmask;
    logic             frame_end;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: rtl/bmorph_fifo.sv
module bmorph_fifo
  import bmorph_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QDEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output qstat_t           stat
);

  localparam int LW = $clog2(DEPTH);

  logic [WIDTH-1:0] store [DEPTH];
  logic [LW:0]      wr_ptr;
  logic [LW:0]      rd_ptr;

  assign stat.empty = (wr_ptr == rd_ptr);
  assign stat.full  = (wr_ptr[LW] != rd_ptr[LW]) && (wr_ptr[LW-1:0] == rd_ptr[LW-1:0]);
  assign rdata      = store[rd_ptr[LW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr[LW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

// File: rtl/bmorph_front.sv
module bmorph_front
  import bmorph_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                restart,
  input  logic [$clog2(MAX_COLS+1)-1:0]       cols,
  input  logic [ROWS_W-1:0]                   rows,
  input  logic                                accept,
  input  logic                                op,
  input  logic [PIX_W-1:0]                    pixel_in,
  output logic                                push,
  output ctl_t                                item_ctl,
  output logic [PIX_W-1:0]                    item_pix,
  output logic [$clog2(2*MAX_COLS)-1:0]       wr_addr,
  output logic [$clog2(2*MAX_COLS)-1:0]       mid_addr,
  output logic [$clog2(2*MAX_COLS)-1:0]       top_addr
);

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int PW = $clog2(MAX_COLS + 3);
  localparam int XW = $clog2(MAX_COLS);
  localparam int AW = $clog2(2 * MAX_COLS);

  logic [PW-1:0]       pending;
  logic [PW-1:0]       pending_next;
  logic [PW-1:0]       p_eff;
  logic [PW-1:0]       cols_p;
  logic [XW-1:0]       out_col;
  logic [ROWPOS_W-1:0] out_row;
  logic [AW-1:0]       wp;
  logic [AW-1:0]       ca;
  logic                is_pix;
  logic                emit;
  logic                last_col;
  logic                last_row;
  logic                top_ok;
  logic                bot_ok;
  logic                left_ok;
  logic                right_ok;

  assign cols_p = PW'(cols);
  assign is_pix = (op == OP_PIXEL);
  // pixels received but not yet emitted, counting the one arriving now
  assign p_eff  = is_pix ? pending + 1'b1 : pending;
  assign emit   = is_pix ? (pending >= cols_p + 1'b1) : (pending != '0);
  assign push   = accept && (is_pix || emit);

  assign last_col = (CW'(out_col) == cols - 1'b1);
  assign last_row = (ROWS_W'(out_row) == rows - 1'b1);
  assign top_ok   = (out_row != '0);
  assign bot_ok   = !last_row;
  assign left_ok  = (out_col != '0);
  assign right_ok = !last_col;

  always_comb begin
    if (!is_pix) begin
      pending_next = pending - 1'b1;
    end else if (emit) begin
      pending_next = pending;
    end else begin
      pending_next = pending + 1'b1;
    end
  end

  always_comb begin
    item_ctl.is_pix    = is_pix;
    item_ctl.emit      = emit;
    item_ctl.fwd_mid   = is_pix && (pending == '0);
    item_ctl.fwd_bl    = is_pix && (pending == cols_p - 1'b1);
    item_ctl.fwd_bc    = is_pix && (pending == cols_p);
    item_ctl.frame_end = last_col && last_row;
    item_ctl.vmask[W_TL] = top_ok && left_ok;
    item_ctl.vmask[W_TC] = top_ok;
    item_ctl.vmask[W_TR] = top_ok && right_ok;
    item_ctl.vmask[W_ML] = left_ok;
    item_ctl.vmask[W_MC] = 1'b1;
    item_ctl.vmask[W_MR] = right_ok && (p_eff >= PW'(2));
    item_ctl.vmask[W_BL] = bot_ok && left_ok && (p_eff >= cols_p);
    item_ctl.vmask[W_BC] = bot_ok && (p_eff >= cols_p + 1'b1);
    item_ctl.vmask[W_BR] = bot_ok && right_ok && (p_eff >= cols_p + PW'(2));
  end

  assign item_pix = pixel_in;
  assign wr_addr  = wp;
  assign mid_addr = ca + 1'b1;
  assign top_addr = ca - AW'(cols) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      out_col <= '0;
      out_row <= '0;
      wp      <= '0;
      ca      <= '0;
    end else if (restart) begin
      pending <= '0;
      out_col <= '0;
      out_row <= '0;
      ca      <= wp;
    end else if (push) begin
      pending <= pending_next;
      if (is_pix) begin
        wp <= wp + 1'b1;
      end
      if (emit) begin
        ca <= ca + 1'b1;
        if (last_col) begin
          out_col <= '0;
          out_row <= last_row ? '0 : out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/bmorph_back.sv
module bmorph_back
  import bmorph_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  ctl_t                          q_ctl,
  input  logic [PIX_W-1:0]              q_pix,
  input  logic [$clog2(2*MAX_COLS)-1:0] q_wr_addr,
  input  logic [$clog2(2*MAX_COLS)-1:0] q_mid_addr,
  input  logic [$clog2(2*MAX_COLS)-1:0] q_top_addr,
  input  mode_t                         mode,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [PIX_W-1:0]              pixel_out,
  output logic                          frame_end
);

  localparam int AW    = $clog2(2 * MAX_COLS);
  localparam int DEPTH = 2 ** AW;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_mid;
  logic [PIX_W-1:0] rd_top;
  logic [PIX_W-1:0] b_pix;
  ctl_t             b_ctl;
  logic             b_valid;
  logic             b_adv;
  logic             a_adv;
  logic [PIX_W-1:0] w_tl;
  logic [PIX_W-1:0] w_tc;
  logic [PIX_W-1:0] w_ml;
  logic [PIX_W-1:0] w_mc;
  logic [PIX_W-1:0] w_bl;
  logic [PIX_W-1:0] w_bc;
  logic [PIX_W-1:0] win [WIN_N];
  logic             any_zero;
  logic             any_full;
  logic [PIX_W-1:0] ero;
  logic [PIX_W-1:0] dil;
  logic [PIX_W-1:0] res;

  assign b_adv   = b_valid && (!b_ctl.emit || !out_valid || out_ready);
  assign q_ready = !b_valid || b_adv;
  assign a_adv   = q_valid && q_ready;

  // read-first: the top-right read may hit the slot being overwritten
  always_ff @(posedge clk) begin
    if (a_adv) begin
      if (q_ctl.is_pix) begin
        mem[q_wr_addr] <= q_pix;
      end
      rd_mid <= mem[q_mid_addr];
      rd_top <= mem[q_top_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_ctl <= q_ctl;
      b_pix <= q_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (q_ready) begin
      b_valid <= q_valid;
    end
  end

  always_comb begin
    win[W_TL] = w_tl;
    win[W_TC] = w_tc;
    win[W_TR] = rd_top;
    win[W_ML] = w_ml;
    win[W_MC] = w_mc;
    win[W_MR] = rd_mid;
    win[W_BL] = w_bl;
    win[W_BC] = w_bc;
    win[W_BR] = b_pix;
    any_zero  = 1'b0;
    any_full  = 1'b0;
    for (int i = 0; i < WIN_N; i++) begin
      if (b_ctl.vmask[i] && (win[i] == '0)) begin
        any_zero = 1'b1;
      end
      if (b_ctl.vmask[i] && (win[i] == PIX_MAX)) begin
        any_full = 1'b1;
      end
    end
  end

  assign ero = any_zero ? '0 : w_mc;
  assign dil = any_full ? PIX_MAX : w_mc;

  always_comb begin
    case (mode)
      MODE_ERODE:  res = ero;
      MODE_DILATE: res = dil;
      MODE_INNER:  res = w_mc - ero;
      MODE_OUTER:  res = dil - w_mc;
      default:     res = ero;
    endcase
  end

  // shift the window on a result, else patch slots that just arrived
  always_ff @(posedge clk) begin
    if (b_adv) begin
      if (b_ctl.emit) begin
        w_tl <= w_tc;
        w_tc <= rd_top;
        w_ml <= w_mc;
        w_mc <= rd_mid;
        w_bl <= w_bc;
        w_bc <= b_pix;
      end else begin
        if (b_ctl.fwd_mid) begin
          w_mc <= b_pix;
        end
        if (b_ctl.fwd_bl) begin
          w_bl <= b_pix;
        end
        if (b_ctl.fwd_bc) begin
          w_bc <= b_pix;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv && b_ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_ctl.emit) begin
      pixel_out <= res;
      frame_end <= b_ctl.frame_end;
    end
  end

endmodule

// File: rtl/binary_morphology_3x3.sv
// 3x3 binary erosion / dilation / contour on a raster pixel stream.
//
// Input channel (in_valid/in_ready): op 0 carries a pixel in pixel_in, op 1 is a
// drain request that flushes one pending result. Output channel
// (out_valid/out_ready) carries pixel_out and frame_end, set on the last pixel
// of a frame. Config port: cfg_we writes cfg_wdata to register cfg_index
// (0 mode, 1 frame_cols, 2 frame_rows); write only while idle. A geometry
// write restarts the frame and drops pending results.
//
// A result belongs to the pixel one row plus one pixel earlier; it leaves on
// out_valid once its completing request passes the queue, b stage and output
// register. Unless the output stalls, throughput is one request per cycle, set
// by the line memory's one pixel write and two reads (row above, next pixel).
//
// Reset clears positions and counters and loads mode 0, 1024 x 1024; the line
// memory is not cleared. A stalled receiver holds the output register, the
// back end then stops on its next result, and the small request queue fills
// before in_ready drops.
module binary_morphology_3x3
  import bmorph_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [PIX_W-1:0]     pixel_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     pixel_out,
  output logic                 frame_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int AW = $clog2(2 * MAX_COLS);
  localparam int QW = $bits(ctl_t) + PIX_W + 3 * AW;

  mode_t              mode;
  logic [COLS_W-1:0]  cols_reg;
  logic [ROWS_W-1:0]  rows_reg;
  logic [31:0]        cols_wide;
  logic [CW-1:0]      eff_cols;
  logic [ROWS_W-1:0]  eff_rows;
  logic               restart;
  logic               accept;

  logic               q_push;
  logic               q_pop;
  logic               q_ready;
  qstat_t             q_stat;
  logic [QW-1:0]      q_wdata;
  logic [QW-1:0]      q_rdata;

  ctl_t               f_ctl;
  logic [PIX_W-1:0]   f_pix;
  logic [AW-1:0]      f_wr;
  logic [AW-1:0]      f_mid;
  logic [AW-1:0]      f_top;

  ctl_t               q_ctl;
  logic [PIX_W-1:0]   q_pix;
  logic [AW-1:0]      q_wr;
  logic [AW-1:0]      q_mid;
  logic [AW-1:0]      q_top;

  // config registers; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_ERODE;
      cols_reg <= COLS_RESET;
      rows_reg <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode     <= mode_t'(cfg_wdata[1:0]);
        REG_COLS: cols_reg <= cfg_wdata[COLS_W-1:0];
        REG_ROWS: rows_reg <= cfg_wdata[ROWS_W-1:0];
        default:  ;
      endcase
    end
  end

  assign restart   = cfg_we && ((cfg_index == REG_COLS) || (cfg_index == REG_ROWS));
  assign cols_wide = 32'(cols_reg);

  // clamp geometry: zero counts as one, oversize saturates
  always_comb begin
    if (cols_reg == '0) begin
      eff_cols = CW'(1);
    end else if (cols_wide > 32'(MAX_COLS)) begin
      eff_cols = CW'(MAX_COLS);
    end else begin
      eff_cols = cols_wide[CW-1:0];
    end
  end

  always_comb begin
    if (rows_reg == '0) begin
      eff_rows = ROWS_W'(1);
    end else if (rows_reg > ROWS_W'(MAX_ROWS)) begin
      eff_rows = ROWS_W'(MAX_ROWS);
    end else begin
      eff_rows = rows_reg;
    end
  end

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // front: position tracking, window validity and line memory addresses
  bmorph_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .cols     (eff_cols),
    .rows     (eff_rows),
    .accept   (accept),
    .op       (op),
    .pixel_in (pixel_in),
    .push     (q_push),
    .item_ctl (f_ctl),
    .item_pix (f_pix),
    .wr_addr  (f_wr),
    .mid_addr (f_mid),
    .top_addr (f_top)
  );

  assign q_wdata = {f_ctl, f_pix, f_wr, f_mid, f_top};
  assign {q_ctl, q_pix, q_wr, q_mid, q_top} = q_rdata;
  assign q_pop = !q_stat.empty && q_ready;

  bmorph_fifo #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: line memory, window registers, operator and output register
  bmorph_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (!q_stat.empty),
    .q_ready    (q_ready),
    .q_ctl      (q_ctl),
    .q_pix      (q_pix),
    .q_wr_addr  (q_wr),
    .q_mid_addr (q_mid),
    .q_top_addr (q_top),
    .mode       (mode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_end  (frame_end)
  );

  a_queue_no_overrun: assert property (
    @(posedge clk) disable iff (rst) q_push |-> !q_stat.full
  ) else $error("request queue written while full");

  a_queue_fills: assert property (
    @(posedge clk) disable iff (rst) (q_push && !q_pop) |=> !q_stat.empty
  ) else $error("request queue empty after a push without a pop");

endmodule
